// File: sv/vrt_pkg.sv
// Shared types and constants for the volume rotation core.
// No dependencies; used by every other file of the block except vrt_ram.
package vrt_pkg;

    localparam int REG_W     = 54;  // width of one packed coefficient row
    localparam int SIZE_W    = 7;   // width of a size register
    localparam int COORD_W   = 6;   // width of one request coordinate
    localparam int CFG_IDX_W = 3;   // width of the register index
    localparam int NB        = 8;   // neighbors of one interpolation point
    localparam int SXY_W     = 2 * SIZE_W;
    localparam int LIN_W     = 21;  // linear voxel index before trimming

    // The two request kinds on tuser.
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_X  = 3'd0,
        CFG_ROW_Y  = 3'd1,
        CFG_ROW_Z  = 3'd2,
        CFG_SIZE_X = 3'd3,
        CFG_SIZE_Y = 3'd4,
        CFG_SIZE_Z = 3'd5,
        CFG_COPY   = 3'd6
    } cfg_reg_t;

    // Control bits that travel with a request behind the address stage.
    typedef struct packed {
        logic          is_compute;
        logic          force_zero;
        logic          do_write;
        logic [NB-1:0] nb_ok;      // neighbor is inside the volume and used in the blend
    } item_ctrl_t;

endpackage

// File: sv/vrt_ram.sv
// One copy of the sample store: one write port and one registered read port.
// No dependencies.
module vrt_ram #(
    parameter int DEPTH = 262144,
    parameter int AW    = 18,
    parameter int DW    = 16
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/vrt_xform.sv
// Coordinate pipeline: centering, rotation, bounds checks and base voxel index.
// Depends on vrt_pkg.
module vrt_xform #(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                in_cmd,
    input  logic signed [SAMPLE_BITS-1:0]       in_sample,
    input  logic [vrt_pkg::COORD_W-1:0]         in_x,
    input  logic [vrt_pkg::COORD_W-1:0]         in_y,
    input  logic [vrt_pkg::COORD_W-1:0]         in_z,
    input  logic [vrt_pkg::REG_W-1:0]           row_x,
    input  logic [vrt_pkg::REG_W-1:0]           row_y,
    input  logic [vrt_pkg::REG_W-1:0]           row_z,
    input  logic [vrt_pkg::SIZE_W-1:0]          sx,
    input  logic [vrt_pkg::SIZE_W-1:0]          sy,
    input  logic [vrt_pkg::SIZE_W-1:0]          sz,
    input  logic [vrt_pkg::SXY_W-1:0]           sxy,
    input  logic                                copy_mode,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [vrt_pkg::LIN_W-1:0]           out_base,
    output logic [COEF_FRAC_BITS:0]             out_fr_x,
    output logic [COEF_FRAC_BITS:0]             out_fr_y,
    output logic [COEF_FRAC_BITS:0]             out_fr_z,
    output vrt_pkg::item_ctrl_t                 out_ctrl,
    output logic signed [SAMPLE_BITS-1:0]       out_sample
);

    localparam int CB   = COEF_FRAC_BITS + 2;
    localparam int PF   = COEF_FRAC_BITS + 1;
    localparam int PR_W = CB + 9;
    localparam int P_W  = CB + 11;
    localparam int SW   = vrt_pkg::SIZE_W;
    localparam int LW   = vrt_pkg::LIN_W;

    logic en0, en1, en2, en3;

    // Stage 0: captured request.
    logic                             v0_reg, cmd0_reg;
    logic signed [SAMPLE_BITS-1:0]    smp0_reg;
    logic [vrt_pkg::COORD_W-1:0]      c0_reg [3];

    // Stage 1: coefficient products.
    logic                             v1_reg, cmd1_reg, inv1_reg;
    logic signed [SAMPLE_BITS-1:0]    smp1_reg;
    logic [vrt_pkg::COORD_W-1:0]      c1_reg [3];
    logic signed [PR_W-1:0]           prod1_reg [3][3];

    // Stage 2: source point split into integer and fraction.
    logic                             v2_reg, cmd2_reg, zero2_reg, wr2_reg, copy2_reg;
    logic signed [SAMPLE_BITS-1:0]    smp2_reg;
    logic [SW-1:0]                    ip2_reg [3];
    logic [PF-1:0]                    fr2_reg [3];

    // Stage 3: base index and neighbor flags.
    logic                             v3_reg;
    logic [LW-1:0]                    base3_reg;
    logic [PF-1:0]                    fr3_reg [3];
    vrt_pkg::item_ctrl_t              ctrl3_reg;
    logic signed [SAMPLE_BITS-1:0]    smp3_reg;

    logic [SW-1:0]                    size_a [3];
    logic [vrt_pkg::REG_W-1:0]        rows [3];
    logic [3*CB-1:0]                  cvec [3];
    logic signed [8:0]                cen [3];
    logic                             inv_a;
    logic signed [P_W-1:0]            p_b [3];
    logic signed [P_W-1:0]            lim_b [3];
    logic                             oob_b;
    logic [LW-1:0]                    base_c;
    logic [2:0]                       up_ok_c;
    vrt_pkg::item_ctrl_t              ctrl_next;

    assign size_a = '{sx, sy, sz};
    assign rows   = '{row_x, row_y, row_z};

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign en0      = !v0_reg || en1;
    assign in_ready = en0;

    // Centered coordinates in half units: 2c - s.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            cen[a]  = $signed({2'b00, c0_reg[a], 1'b0}) - $signed({2'b00, size_a[a]});
            cvec[a] = (3*CB)'(rows[a]);
        end
        inv_a = ({1'b0, c0_reg[0]} < sx) && ({1'b0, c0_reg[1]} < sy)
             && ({1'b0, c0_reg[2]} < sz);
    end

    // Rotated point with PF fraction bits and its legal range.
    always_comb begin
        oob_b = 1'b0;
        for (int a = 0; a < 3; a++) begin
            p_b[a] = $signed({{(P_W-SW-COEF_FRAC_BITS){1'b0}}, size_a[a],
                              {COEF_FRAC_BITS{1'b0}}})
                   + P_W'(prod1_reg[a][0]) + P_W'(prod1_reg[a][1])
                   + P_W'(prod1_reg[a][2]);
            lim_b[a] = $signed({{(P_W-SW-PF){1'b0}}, size_a[a] - SW'(1), {PF{1'b0}}});
            if (p_b[a][P_W-1] || (p_b[a] > lim_b[a])) begin
                oob_b = 1'b1;
            end
        end
    end

    // Base index and whether the upper neighbor along each axis exists.
    always_comb begin
        base_c = LW'(ip2_reg[0]) + LW'(ip2_reg[1]) * LW'(sx)
               + LW'(ip2_reg[2]) * LW'(sxy);
        up_ok_c[0] = (LW'(ip2_reg[0]) + LW'(1)) < LW'(sx);
        up_ok_c[1] = (LW'(ip2_reg[1]) + LW'(1)) < LW'(sy);
        up_ok_c[2] = (LW'(ip2_reg[2]) + LW'(1)) < LW'(sz);
        ctrl_next.is_compute = cmd2_reg;
        ctrl_next.force_zero = zero2_reg;
        ctrl_next.do_write   = wr2_reg;
        for (int n = 0; n < vrt_pkg::NB; n++) begin
            ctrl_next.nb_ok[n] = (n == 0) ||
                (!copy2_reg && cmd2_reg
                 && (!n[0] || up_ok_c[0]) && (!n[1] || up_ok_c[1])
                 && (!n[2] || up_ok_c[2]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en0) v0_reg <= in_valid;
            if (en1) v1_reg <= v0_reg;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en0 && in_valid) begin
            cmd0_reg  <= in_cmd;
            smp0_reg  <= in_sample;
            c0_reg[0] <= in_x;
            c0_reg[1] <= in_y;
            c0_reg[2] <= in_z;
        end
        if (en1) begin
            cmd1_reg <= cmd0_reg;
            smp1_reg <= smp0_reg;
            inv1_reg <= inv_a;
            c1_reg   <= c0_reg;
            for (int a = 0; a < 3; a++) begin
                for (int j = 0; j < 3; j++) begin
                    prod1_reg[a][j] <= PR_W'($signed(cvec[a][j*CB +: CB]) * cen[j]);
                end
            end
        end
        if (en2) begin
            cmd2_reg  <= cmd1_reg;
            smp2_reg  <= smp1_reg;
            copy2_reg <= copy_mode;
            wr2_reg   <= (cmd1_reg == vrt_pkg::CMD_LOAD) && inv1_reg;
            // Loads and copies address the request coordinate itself.
            if ((cmd1_reg == vrt_pkg::CMD_LOAD) || copy_mode) begin
                zero2_reg <= !inv1_reg;
                for (int a = 0; a < 3; a++) begin
                    ip2_reg[a] <= {1'b0, c1_reg[a]};
                    fr2_reg[a] <= '0;
                end
            end else begin
                zero2_reg <= !inv1_reg || oob_b;
                for (int a = 0; a < 3; a++) begin
                    ip2_reg[a] <= p_b[a][PF +: SW];
                    fr2_reg[a] <= p_b[a][PF-1:0];
                end
            end
        end
        if (en3) begin
            base3_reg <= base_c;
            fr3_reg   <= fr2_reg;
            ctrl3_reg <= ctrl_next;
            smp3_reg  <= smp2_reg;
        end
    end

    assign out_valid  = v3_reg;
    assign out_base   = base3_reg;
    assign out_fr_x   = fr3_reg[0];
    assign out_fr_y   = fr3_reg[1];
    assign out_fr_z   = fr3_reg[2];
    assign out_ctrl   = ctrl3_reg;
    assign out_sample = smp3_reg;

endmodule

// File: sv/vrt_interp.sv
// Trilinear blend: x, then y, then z, each rounded, plus the output register.
// Depends on vrt_pkg.
module vrt_interp #(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [SAMPLE_BITS-1:0]        in_vox [vrt_pkg::NB],
    input  logic [COEF_FRAC_BITS:0]       in_fr_x,
    input  logic [COEF_FRAC_BITS:0]       in_fr_y,
    input  logic [COEF_FRAC_BITS:0]       in_fr_z,
    input  vrt_pkg::item_ctrl_t           in_ctrl,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_voxel
);

    localparam int PF = COEF_FRAC_BITS + 1;
    localparam int SB = SAMPLE_BITS;
    localparam int AW = SB + PF + 3;

    // a*(1-f) + b*f, rounded to nearest with halves going up.
    function automatic logic signed [SB-1:0] lerp(input logic signed [SB-1:0] a,
                                                   input logic signed [SB-1:0] b,
                                                   input logic [PF-1:0] f);
        logic signed [PF+1:0] wa;
        logic signed [PF+1:0] wb;
        logic signed [AW-1:0] acc;
        wb  = $signed({2'b00, f});
        wa  = $signed((PF+2)'(1) << PF) - wb;
        acc = a * wa + b * wb + $signed(AW'(1) << (PF - 1));
        return acc[PF +: SB];
    endfunction

    logic en5, en6, en7;
    logic v5_reg, v6_reg, v7_reg;
    logic signed [SB-1:0] l1_reg [4];
    logic signed [SB-1:0] l2_reg [2];
    logic signed [SB-1:0] out_reg;
    logic [PF-1:0] fy5_reg, fz5_reg, fz6_reg;
    logic zero5_reg, zero6_reg, cmp5_reg, cmp6_reg;
    logic signed [SB-1:0] vox_m [vrt_pkg::NB];

    assign en7      = !v7_reg || out_ready;
    assign en6      = !v6_reg || en7;
    assign en5      = !v5_reg || en6;
    assign in_ready = en5;

    // Neighbors outside the volume count as zero.
    always_comb begin
        for (int n = 0; n < vrt_pkg::NB; n++) begin
            vox_m[n] = in_ctrl.nb_ok[n] ? $signed(in_vox[n]) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else begin
            if (en5) v5_reg <= in_valid;
            if (en6) v6_reg <= v5_reg;
            if (en7) v7_reg <= v6_reg && cmp6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en5) begin
            for (int k = 0; k < 4; k++) begin
                l1_reg[k] <= lerp(vox_m[2*k], vox_m[2*k+1], in_fr_x);
            end
            fy5_reg   <= in_fr_y;
            fz5_reg   <= in_fr_z;
            zero5_reg <= in_ctrl.force_zero;
            cmp5_reg  <= in_ctrl.is_compute;
        end
        if (en6) begin
            l2_reg[0] <= lerp(l1_reg[0], l1_reg[1], fy5_reg);
            l2_reg[1] <= lerp(l1_reg[2], l1_reg[3], fy5_reg);
            fz6_reg   <= fz5_reg;
            zero6_reg <= zero5_reg;
            cmp6_reg  <= cmp5_reg;
        end
        if (en7) begin
            out_reg <= zero6_reg ? '0 : lerp(l2_reg[0], l2_reg[1], fz6_reg);
        end
    end

    assign out_valid = v7_reg;
    assign out_voxel = out_reg;

endmodule

// File: sv/volume_rotate_trilinear_core.sv
// Top level of the volume rotation core with trilinear resampling.
// Depends on vrt_pkg, vrt_ram, vrt_xform and vrt_interp.
//
//  channel   | direction | handshake                     | contents
//  ----------+-----------+-------------------------------+---------------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready | command, sample, coordinates
//  m_axis    | out       | m_axis_tvalid / m_axis_tready | rotated output voxel
//  cfg       | in        | cfg_we, no wait               | rotation rows, sizes, copy mode
//
// One request enters per cycle while the pipeline is not stalled. A compute request
// passes four coordinate stages, one memory stage, two blend stages and the output
// register before its voxel appears. The eight neighbors are fetched together from eight
// copies of the store, all written together by load requests. Reset clears
// the valid bits of all stages and sets the registers to their defaults; the
// store itself is not cleared. A stall on m_axis backs up stage by stage, so
// empty stages keep taking requests until the pipeline is full.
module volume_rotate_trilinear_core #(
    parameter int MAX_DIM        = 64,
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // sample_in, coord_x, coord_y, coord_z, zero fill
    input  logic [((SAMPLE_BITS+18+7)/8)*8-1:0] s_axis_tdata,
    // command
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // voxel_out, zero fill
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata,
    input  logic                               cfg_we,
    input  logic [vrt_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [vrt_pkg::REG_W-1:0]          cfg_wdata
);

    localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int OW    = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int SW    = vrt_pkg::SIZE_W;
    localparam int LW    = vrt_pkg::LIN_W;
    localparam int PF    = COEF_FRAC_BITS + 1;
    localparam int CW    = vrt_pkg::COORD_W;

    // Configuration registers.
    logic [vrt_pkg::REG_W-1:0] row_reg [3];
    logic [SW-1:0]             size_reg [3];
    logic                      copy_reg;
    logic [SW-1:0]             size_eff [3];
    logic [vrt_pkg::SXY_W-1:0] sxy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                row_reg[a]  <= '0;
                size_reg[a] <= SW'(64);
            end
            copy_reg <= 1'b1;
        end else if (cfg_we) begin
            unique case (vrt_pkg::cfg_reg_t'(cfg_addr))
                vrt_pkg::CFG_ROW_X:  row_reg[0]  <= cfg_wdata;
                vrt_pkg::CFG_ROW_Y:  row_reg[1]  <= cfg_wdata;
                vrt_pkg::CFG_ROW_Z:  row_reg[2]  <= cfg_wdata;
                vrt_pkg::CFG_SIZE_X: size_reg[0] <= cfg_wdata[SW-1:0];
                vrt_pkg::CFG_SIZE_Y: size_reg[1] <= cfg_wdata[SW-1:0];
                vrt_pkg::CFG_SIZE_Z: size_reg[2] <= cfg_wdata[SW-1:0];
                vrt_pkg::CFG_COPY:   copy_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // A zero size acts as one and a size beyond the store acts as its edge.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            priority if (size_reg[a] == '0) begin
                size_eff[a] = SW'(1);
            end else if (32'(size_reg[a]) > MAX_DIM) begin
                size_eff[a] = SW'(MAX_DIM);
            end else begin
                size_eff[a] = size_reg[a];
            end
        end
    end

    // Slice stride; the user must write registers only while the block is idle, long
    // before a request reaches the index stage; the block does not enforce this.
    always_ff @(posedge aclk) begin
        sxy_reg <= size_eff[0] * size_eff[1];
    end

    // Coordinate pipeline.
    logic                          x_valid, x_ready;
    logic [LW-1:0]                 x_base;
    logic [PF-1:0]                 x_fr_x, x_fr_y, x_fr_z;
    vrt_pkg::item_ctrl_t           x_ctrl;
    logic signed [SAMPLE_BITS-1:0] x_sample;

    vrt_xform #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_xform (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_cmd     (s_axis_tuser),
        .in_sample  ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
        .in_x       (s_axis_tdata[SAMPLE_BITS +: CW]),
        .in_y       (s_axis_tdata[SAMPLE_BITS+CW +: CW]),
        .in_z       (s_axis_tdata[SAMPLE_BITS+2*CW +: CW]),
        .row_x      (row_reg[0]),
        .row_y      (row_reg[1]),
        .row_z      (row_reg[2]),
        .sx         (size_eff[0]),
        .sy         (size_eff[1]),
        .sz         (size_eff[2]),
        .sxy        (sxy_reg),
        .copy_mode  (copy_reg),
        .out_valid  (x_valid),
        .out_ready  (x_ready),
        .out_base   (x_base),
        .out_fr_x   (x_fr_x),
        .out_fr_y   (x_fr_y),
        .out_fr_z   (x_fr_z),
        .out_ctrl   (x_ctrl),
        .out_sample (x_sample)
    );

    // Memory stage. Loads write here and computes read here, so requests
    // see the store in the order they were accepted.
    logic                     en4, s4_valid_reg, ip_ready;
    logic [PF-1:0]            fr4_reg [3];
    vrt_pkg::item_ctrl_t      ctrl4_reg;
    logic                     ram_we;
    logic [IDX_W-1:0]         nb_addr [vrt_pkg::NB];
    logic [SAMPLE_BITS-1:0]   nb_data [vrt_pkg::NB];

    assign en4     = !s4_valid_reg || ip_ready;
    assign x_ready = en4;
    assign ram_we  = x_valid && en4 && x_ctrl.do_write;

    always_comb begin
        for (int n = 0; n < vrt_pkg::NB; n++) begin
            nb_addr[n] = IDX_W'(x_base + (n[0] ? LW'(1) : '0)
                              + (n[1] ? LW'(size_eff[0]) : '0)
                              + (n[2] ? LW'(sxy_reg) : '0));
        end
    end

    for (genvar g = 0; g < vrt_pkg::NB; g++) begin : g_bank
        vrt_ram #(
            .DEPTH (DEPTH),
            .AW    (IDX_W),
            .DW    (SAMPLE_BITS)
        ) u_ram (
            .aclk  (aclk),
            .we    (ram_we),
            .waddr (nb_addr[0]),
            .wdata (x_sample),
            .re    (en4),
            .raddr (nb_addr[g]),
            .rdata (nb_data[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (en4) begin
            s4_valid_reg <= x_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            fr4_reg[0] <= x_fr_x;
            fr4_reg[1] <= x_fr_y;
            fr4_reg[2] <= x_fr_z;
            ctrl4_reg  <= x_ctrl;
        end
    end

    // Blend stages and output register.
    logic signed [SAMPLE_BITS-1:0] voxel;

    vrt_interp #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_interp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s4_valid_reg),
        .in_ready  (ip_ready),
        .in_vox    (nb_data),
        .in_fr_x   (fr4_reg[0]),
        .in_fr_y   (fr4_reg[1]),
        .in_fr_z   (fr4_reg[2]),
        .in_ctrl   (ctrl4_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_voxel (voxel)
    );

    assign m_axis_tdata = OW'($unsigned(voxel));

`ifndef ASSERT_OFF
    // A compute request never writes the store.
    a_no_compute_write: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !x_ctrl.is_compute)
        else $error("store written by a compute request");

    // Loads carry no blend fraction into the memory stage.
    a_load_no_frac: assert property (@(posedge aclk) disable iff (!aresetn)
        (x_valid && !x_ctrl.is_compute) |->
        (x_fr_x == '0 && x_fr_y == '0 && x_fr_z == '0))
        else $error("load request carries a fraction");

    // A request that leaves the coordinate pipeline lands in the memory stage.
    a_mem_stage_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (x_valid && en4) |=> s4_valid_reg)
        else $error("request lost at the memory stage");
`endif

endmodule
